[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also runs across the reset edge.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/lpbp_pkg.sv]
// Types, codes and byte formatting shared by the LCD pixel byte packer.
`timescale 1ns / 1ps

package lpbp_pkg;

  localparam int PIX_W   = 24;  // RGB888 pixel
  localparam int GLYPH_W = 8;   // glyph row bits
  localparam int GW_W    = 4;   // glyph width register and pixel counters
  localparam int BYTE_W  = 8;

  typedef enum logic [1:0] {
    MODE_12 = 2'd0,
    MODE_16 = 2'd1,
    MODE_18 = 2'd2,
    MODE_24 = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_BUS_FMT     = 2'd0,
    REG_FG_COLOR    = 2'd1,
    REG_BG_COLOR    = 2'd2,
    REG_GLYPH_WIDTH = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_GLYPH = 1'b1
  } cmd_e;

  typedef struct packed {
    mode_e             bus_fmt;
    logic [PIX_W-1:0]  fg_color;
    logic [PIX_W-1:0]  bg_color;
    logic [GW_W-1:0]   glyph_width;
  } cfg_t;

  // One queued item, already classified with its pixel count.
  typedef struct packed {
    cmd_e                cmd;
    logic [PIX_W-1:0]    color;
    logic [GLYPH_W-1:0]  bits;
    logic                last;
    logic [GW_W-1:0]     npix;
  } item_t;

  // Byte sel of a pixel (a) or, in 12-bit mode, of the pair (a, b).
  function automatic logic [BYTE_W-1:0] pack_byte(mode_e mode, logic [1:0] sel,
                                                   logic [PIX_W-1:0] a,
                                                   logic [PIX_W-1:0] b);
    logic [7:0] ra, ga, ba, rb, gb, bb, comp;
    logic [BYTE_W-1:0] res;
    ra = a[23:16]; ga = a[15:8]; ba = a[7:0];
    rb = b[23:16]; gb = b[15:8]; bb = b[7:0];
    case (sel)
      2'd0:    comp = ra;
      2'd1:    comp = ga;
      default: comp = ba;
    endcase
    unique case (mode)
      MODE_12: begin
        case (sel)
          2'd0:    res = {ra[7:4], ga[7:4]};
          2'd1:    res = {ba[7:4], rb[7:4]};
          default: res = {gb[7:4], bb[7:4]};
        endcase
      end
      MODE_16: begin
        if (sel == 2'd0) begin
          res = {ra[7:3], ga[7:5]};
        end else begin
          res = {ga[4:2], ba[7:3]};
        end
      end
      MODE_18: res = {comp[7:2], 2'b00};
      default: res = comp;
    endcase
    return res;
  endfunction

endpackage

[src/lcd_pixel_byte_packer_core.sv]
// Top level of the LCD pixel byte packer: config registers, front end, queue, back end.
`timescale 1ns / 1ps

// Turns RGB888 pixels and glyph rows into the byte stream of an 8-bit parallel
// LCD data bus. bus_fmt picks the bus format: 12-bit packs two RGB444 pixels
// into three bytes, 16-bit sends RGB565 as two bytes, 18-bit sends three bytes
// with the two low bits cleared, 24-bit sends r, g, b raw. A glyph-row beat
// (in_tuser=1) expands glyph_width bits from bit 7 down into fg/bg pixels. In
// 12-bit mode an unpaired pixel is held across beats; a beat with in_tlast set
// flushes it paired with itself. A beat processed in any other mode drops a held
// pixel. out_tlast marks the final byte a beat produces; a beat that produces no
// byte yields nothing. The output register sends one byte per cycle while
// out_tready accepts it: two per pixel in 16-bit mode, three in 18/24-bit
// mode, three per pair in 12-bit mode after a step that holds the first pixel;
// a beat with no byte still takes a step. A two-entry queue decouples input
// acceptance from byte generation, so in_tready stays high until two beats
// wait. Configuration writes take effect on the next cycle and must be made
// while the block is idle. Reset is synchronous, active low.
module lcd_pixel_byte_packer_core #(
  parameter int MAX_GLYPH_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [23:0] color, [31:24] glyph_bits
  input  logic        in_tuser,   // [0] cmd: 0 pixel, 1 glyph row
  input  logic        in_tlast,   // ends the pixel run
  // output byte stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] data_byte
  output logic        out_tlast,  // last byte of the input beat
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);
  import lpbp_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  item_t  f_item, h_item;
  logic   q_push, q_full, q_pop, h_valid;

  // Register file: one write per cycle, no read-back.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_e'(cfg_addr))
        REG_BUS_FMT:     cfg_nxt.bus_fmt     = mode_e'(cfg_wdata[1:0]);
        REG_FG_COLOR:    cfg_nxt.fg_color    = cfg_wdata[PIX_W-1:0];
        REG_BG_COLOR:    cfg_nxt.bg_color    = cfg_wdata[PIX_W-1:0];
        REG_GLYPH_WIDTH: cfg_nxt.glyph_width = cfg_wdata[GW_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_fmt     <= MODE_24;
      cfg_r.fg_color    <= 24'hFFFFFF;
      cfg_r.bg_color    <= 24'h000000;
      cfg_r.glyph_width <= GW_W'(8);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accept and classify beats.
  lpbp_front #(
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
  ) u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .glyph_width (cfg_r.glyph_width),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (f_item)
  );

  // Queue between front and back.
  lpbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (f_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (h_valid),
    .head_item  (h_item)
  );

  // Back end: pixel walk, 12-bit pairing, byte output register.
  lpbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (h_valid),
    .head_item  (h_item),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[src/lpbp_front.sv]
// Front end: accepts input beats and classifies them into queue items.
`timescale 1ns / 1ps

module lpbp_front #(
  parameter int MAX_GLYPH_WIDTH = 8
) (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  input  logic [lpbp_pkg::GW_W-1:0]     glyph_width,
  input  logic                          q_full,
  output logic                          q_push,
  output lpbp_pkg::item_t               q_item
);
  import lpbp_pkg::*;

  localparam logic [GW_W-1:0] MAX_W = GW_W'(MAX_GLYPH_WIDTH);

  logic [GW_W-1:0] row_w;

  // Glyph width saturates at the widest row the unit supports.
  assign row_w     = (glyph_width > MAX_W) ? MAX_W : glyph_width;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.cmd   = cmd_e'(in_tuser);
    q_item.color = in_tdata[PIX_W-1:0];
    q_item.bits  = in_tdata[PIX_W+GLYPH_W-1:PIX_W];
    q_item.last  = in_tlast;
    q_item.npix  = (in_tuser == CMD_GLYPH) ? row_w : GW_W'(1);
  end

endmodule

[src/lpbp_queue.sv]
// Two-entry item queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module lpbp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lpbp_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output lpbp_pkg::item_t  head_item
);
  import lpbp_pkg::*;

  item_t       mem_r [2];
  logic        wr_r, wr_nxt;
  logic        rd_r, rd_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

[src/lpbp_back.sv]
// Back end: walks each item's pixels and emits one bus byte per cycle while out_tready accepts.
`timescale 1ns / 1ps

module lpbp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpbp_pkg::cfg_t                cfg,
  input  logic                          head_valid,
  input  lpbp_pkg::item_t               head_item,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,
  output logic                          out_tlast
);
  import lpbp_pkg::*;

  logic [GW_W-1:0]    pix_r, pix_nxt;
  logic [1:0]         byte_r, byte_nxt;
  logic [PIX_W-1:0]   held_r, held_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic               step, eff_held, in_pix, emit, is_last;
  logic [GW_W-1:0]    rem, k;
  logic [GLYPH_W-1:0] bits_sh;
  logic [PIX_W-1:0]   px;
  logic [BYTE_W-1:0]  byte_val;

  assign step     = head_valid && (!out_valid_r || out_tready);
  assign eff_held = held_valid_r && (cfg.bus_fmt == MODE_12);
  assign in_pix   = (pix_r != head_item.npix);
  assign rem      = head_item.npix - pix_r;
  assign k        = rem - GW_W'(1);
  assign bits_sh  = head_item.bits << pix_r;
  assign px       = (head_item.cmd == CMD_GLYPH) ?
                    (bits_sh[GLYPH_W-1] ? cfg.fg_color : cfg.bg_color) :
                    head_item.color;

  always_comb begin
    pix_nxt        = pix_r;
    byte_nxt       = byte_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    emit           = 1'b0;
    is_last        = 1'b0;
    pop            = 1'b0;
    byte_val       = '0;
    if (step) begin
      // any other bus format drops a held 12-bit pixel
      if (cfg.bus_fmt != MODE_12) begin
        held_valid_nxt = 1'b0;
      end
      if (in_pix) begin
        unique case (cfg.bus_fmt)
          MODE_12: begin
            if (!eff_held) begin
              held_nxt       = px;
              held_valid_nxt = 1'b1;
              pix_nxt        = pix_r + GW_W'(1);
              pop            = (k == '0) && !head_item.last;
            end else begin
              emit     = 1'b1;
              byte_val = pack_byte(MODE_12, byte_r, held_r, px);
              if (byte_r == 2'd2) begin
                held_valid_nxt = 1'b0;
                pix_nxt        = pix_r + GW_W'(1);
                byte_nxt       = 2'd0;
                pop            = (k == '0);
                // more bytes follow if another pair forms or a flush does
                is_last        = !((k >= GW_W'(2)) || (head_item.last && k[0]));
              end else begin
                byte_nxt = byte_r + 2'd1;
              end
            end
          end
          MODE_16: begin
            emit     = 1'b1;
            byte_val = pack_byte(MODE_16, byte_r, px, px);
            if (byte_r == 2'd1) begin
              pix_nxt  = pix_r + GW_W'(1);
              byte_nxt = 2'd0;
              pop      = (k == '0);
              is_last  = (k == '0);
            end else begin
              byte_nxt = byte_r + 2'd1;
            end
          end
          default: begin
            emit     = 1'b1;
            byte_val = pack_byte(cfg.bus_fmt, byte_r, px, px);
            if (byte_r == 2'd2) begin
              pix_nxt  = pix_r + GW_W'(1);
              byte_nxt = 2'd0;
              pop      = (k == '0);
              is_last  = (k == '0);
            end else begin
              byte_nxt = byte_r + 2'd1;
            end
          end
        endcase
      end else if (head_item.last && eff_held) begin
        // flush: held pixel paired with itself
        emit     = 1'b1;
        byte_val = pack_byte(MODE_12, byte_r, held_r, held_r);
        if (byte_r == 2'd2) begin
          held_valid_nxt = 1'b0;
          byte_nxt       = 2'd0;
          pop            = 1'b1;
          is_last        = 1'b1;
        end else begin
          byte_nxt = byte_r + 2'd1;
        end
      end else begin
        pop = 1'b1;
      end
      if (pop) begin
        pix_nxt = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = byte_val;
      out_last_nxt  = is_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r        <= '0;
      byte_r       <= 2'd0;
      held_valid_r <= 1'b0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pix_r        <= pix_nxt;
      byte_r       <= byte_nxt;
      held_valid_r <= held_valid_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[src/lpbp_checker.sv]
// Port-level checker for the LCD pixel byte packer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a stalled byte stays put
  `ASSERT_CLK(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)), "stalled output beat changed")

  // no byte is left over from before reset
  `ASSERT_RST(a_out_idle_after_rst, $rose(rst_n) |-> !out_tvalid, "output valid right after reset")

  // queue comes out of reset empty
  `ASSERT_RST(a_in_ready_after_rst, $rose(rst_n) |-> in_tready, "input not ready right after reset")

endmodule

bind lcd_pixel_byte_packer_core lpbp_checker u_lpbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[test/tb_top.sv]
// Self-checking testbench for the LCD pixel byte packer: directed cases, random traffic, stalls.
`timescale 1ns / 1ps

module tb_top;
  import lpbp_pkg::*;

  localparam int GLYPH_PIX_MAX = 8;     // glyph widths above this saturate
  localparam int DRAIN_CYCLES  = 40;    // settle time after the last byte
  localparam int SHOW_MAX      = 10;    // mismatches printed in full

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [23:0] color, [31:24] glyph_bits
  logic        in_tuser;   // [0] cmd
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] data_byte
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  lcd_pixel_byte_packer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // One bus byte as the block should send it.
  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } bus_byte_t;

  bus_byte_t  pending_bytes[$];   // bytes still owed by the block, oldest first
  logic [7:0] beat_bytes[$];      // scratch: bytes of the beat being predicted
  bus_byte_t  head;

  // Shadow of the register file and of the 12-bit pairing state.
  mode_e       sh_mode;
  logic [23:0] sh_fg;
  logic [23:0] sh_bg;
  logic [3:0]  sh_gw;
  logic [23:0] sh_held;
  bit          sh_held_ok;

  int err_count;
  int shown;
  int beats_sent;
  int bytes_seen;
  int beats_per_mode[4];
  int hold_cycles;      // forced receiver hold-off, counted down by the receiver
  int hold_longest;
  int rx_wait;
  bit gaps_on;

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- timeout
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // ---------------------------------------------------------------- predictor
  // RGB444 pair: three bytes carry the high nibbles of A then B.
  function automatic void emit_pair(input logic [23:0] a, input logic [23:0] b);
    beat_bytes.push_back({a[23:20], a[15:12]});
    beat_bytes.push_back({a[7:4], b[23:20]});
    beat_bytes.push_back({b[15:12], b[7:4]});
  endfunction

  function automatic void emit_pixel(input logic [23:0] px);
    case (sh_mode)
      MODE_12: begin
        if (sh_held_ok) begin
          emit_pair(sh_held, px);
          sh_held_ok = 1'b0;
        end else begin
          sh_held    = px;
          sh_held_ok = 1'b1;
        end
      end
      MODE_16: begin
        beat_bytes.push_back({px[23:19], px[15:13]});
        beat_bytes.push_back({px[12:10], px[7:3]});
      end
      MODE_18: begin
        beat_bytes.push_back({px[23:18], 2'b00});
        beat_bytes.push_back({px[15:10], 2'b00});
        beat_bytes.push_back({px[7:2], 2'b00});
      end
      default: begin
        beat_bytes.push_back(px[23:16]);
        beat_bytes.push_back(px[15:8]);
        beat_bytes.push_back(px[7:0]);
      end
    endcase
  endfunction

  // Works out every byte one accepted beat causes and queues them.
  function automatic void predict_beat(input cmd_e cmd, input logic [23:0] color,
                                       input logic [7:0] bits, input bit is_last);
    int n_px;
    beat_bytes.delete();
    // any beat outside 12-bit mode drops a held pixel
    if (sh_mode != MODE_12) sh_held_ok = 1'b0;
    if (cmd == CMD_PIXEL) begin
      emit_pixel(color);
    end else begin
      n_px = (int'(sh_gw) > GLYPH_PIX_MAX) ? GLYPH_PIX_MAX : int'(sh_gw);
      for (int i = 0; i < n_px; i++) begin
        emit_pixel(bits[7-i] ? sh_fg : sh_bg);
      end
    end
    // end of run: a lone 12-bit pixel goes out paired with itself
    if (is_last && sh_mode == MODE_12 && sh_held_ok) begin
      emit_pair(sh_held, sh_held);
      sh_held_ok = 1'b0;
    end
    foreach (beat_bytes[k]) begin
      pending_bytes.push_back('{data: beat_bytes[k], is_last: (k == beat_bytes.size() - 1)});
    end
  endfunction

  // ---------------------------------------------------------------- checker
  task automatic report_error(input string msg);
    err_count++;
    if (shown < SHOW_MAX) begin
      shown++;
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        report_error($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        head = pending_bytes.pop_front();
        if (out_tdata !== head.data || out_tlast !== head.is_last) begin
          report_error($sformatf("byte exp %02h/%0b got %02h/%0b",
                                 head.data, head.is_last, out_tdata, out_tlast));
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // Random ready gaps, plus a forced hold-off when a test asks for one.
  initial begin
    out_tready <= 1'b0;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (!gaps_on) begin
        out_tready <= 1'b1;
      end else if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
        rx_wait = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- sender
  // Offers one beat, waits for the handshake, predicts, then maybe idles.
  task automatic send_beat(input cmd_e cmd, input logic [23:0] color,
                           input logic [7:0] bits, input bit is_last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {bits, color};
    in_tuser  <= cmd;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    predict_beat(cmd, color, bits, is_last);
    beats_sent++;
    beats_per_mode[sh_mode]++;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write, only once the block has gone quiet. Beats that make no
  // byte may still sit in the queue, so it also waits out a settle time after the drain.
  task automatic write_reg(input reg_idx_e idx, input logic [23:0] val);
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BUS_FMT:     sh_mode = mode_e'(val[1:0]);
      REG_FG_COLOR:    sh_fg   = val;
      REG_BG_COLOR:    sh_bg   = val;
      REG_GLYPH_WIDTH: sh_gw   = val[3:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- tests
  // Reset values: 24-bit raw, white on black, 8-pixel rows.
  task automatic test_defaults();
    send_beat(CMD_PIXEL, 24'hFFFFFF, 8'h00, 1'b0);
    send_beat(CMD_PIXEL, 24'h000000, 8'hFF, 1'b0);
    send_beat(CMD_GLYPH, 24'h000000, 8'hA5, 1'b1);
  endtask

  task automatic test_rgb565();
    write_reg(REG_BUS_FMT, 24'(MODE_16));
    write_reg(REG_FG_COLOR, 24'h000000);
    write_reg(REG_BG_COLOR, 24'hFFFFFF);
    write_reg(REG_GLYPH_WIDTH, 24'd2);
    send_beat(CMD_PIXEL, 24'hFFFFFF, 8'h00, 1'b0);
    send_beat(CMD_PIXEL, 24'h000000, 8'h00, 1'b1);
    send_beat(CMD_PIXEL, 24'h5A5A5A, 8'h00, 1'b0);
    send_beat(CMD_GLYPH, 24'h000000, 8'h80, 1'b1);
  endtask

  // 18-bit masking, and a width above the maximum that must saturate.
  task automatic test_rgb666_wide_glyph();
    write_reg(REG_BUS_FMT, 24'(MODE_18));
    write_reg(REG_GLYPH_WIDTH, 24'd15);
    send_beat(CMD_PIXEL, 24'hFFFFFF, 8'h00, 1'b0);
    send_beat(CMD_GLYPH, 24'h000000, 8'hFF, 1'b1);
  endtask

  // Pairing across pixel beats and glyph rows, flush on last.
  task automatic test_rgb444_pairs();
    write_reg(REG_BUS_FMT, 24'(MODE_12));
    write_reg(REG_FG_COLOR, 24'hFFFFFF);
    write_reg(REG_GLYPH_WIDTH, 24'd3);
    send_beat(CMD_PIXEL, 24'hAAAAAA, 8'h00, 1'b0);
    send_beat(CMD_PIXEL, 24'h555555, 8'h00, 1'b0);
    send_beat(CMD_PIXEL, 24'h123456, 8'h00, 1'b1);
    send_beat(CMD_GLYPH, 24'h000000, 8'hA0, 1'b0);
    send_beat(CMD_GLYPH, 24'h000000, 8'h40, 1'b1);
  endtask

  // Zero-width rows give nothing of their own; width 1 is odd.
  task automatic test_narrow_glyph();
    write_reg(REG_GLYPH_WIDTH, 24'd0);
    send_beat(CMD_PIXEL, 24'h0F0F0F, 8'h00, 1'b0);
    send_beat(CMD_GLYPH, 24'h000000, 8'hFF, 1'b0);
    send_beat(CMD_GLYPH, 24'h000000, 8'hFF, 1'b1);
    write_reg(REG_GLYPH_WIDTH, 24'd1);
    send_beat(CMD_GLYPH, 24'h000000, 8'h80, 1'b1);
  endtask

  // A held pixel is lost once a beat goes through in another mode.
  task automatic test_held_drop();
    send_beat(CMD_PIXEL, 24'hABCDEF, 8'h00, 1'b0);
    write_reg(REG_BUS_FMT, 24'(MODE_24));
    send_beat(CMD_PIXEL, 24'h010203, 8'h00, 1'b0);
    write_reg(REG_BUS_FMT, 24'(MODE_12));
    send_beat(CMD_PIXEL, 24'hFEDCBA, 8'h00, 1'b1);
  endtask

  // Receiver holds off while beats keep coming: queue fills, input stalls.
  task automatic test_backpressure();
    logic [23:0] col;
    write_reg(REG_BUS_FMT, 24'(MODE_24));
    gaps_on = 1'b0;
    hold_cycles = 300;
    if (hold_cycles > hold_longest) hold_longest = hold_cycles;
    for (int k = 0; k < 16; k++) begin
      col = 24'($urandom);
      send_beat(CMD_PIXEL, col, 8'h00, k == 15);
    end
    gaps_on = 1'b1;
  endtask

  // Random settings per phase; phases 0..3 walk all modes, the last runs gap-free.
  task automatic test_random_traffic();
    logic [23:0] col;
    logic [7:0]  bits;
    logic [23:0] fg;
    logic [23:0] bg;
    int unsigned gw;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_BUS_FMT, (ph < 4) ? 24'(ph) : 24'($urandom_range(0, 3)));
      fg = 24'($urandom);
      bg = 24'($urandom);
      if ($urandom_range(0, 3) == 0) fg = 24'hFFFFFF;
      if ($urandom_range(0, 3) == 0) bg = 24'h000000;
      write_reg(REG_FG_COLOR, fg);
      write_reg(REG_BG_COLOR, bg);
      gw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 2 * $urandom_range(1, 4);
      write_reg(REG_GLYPH_WIDTH, 24'(gw));
      gaps_on = (ph != 5);
      for (int k = 0; k < 14; k++) begin
        col  = 24'($urandom);
        bits = 8'($urandom);
        send_beat(cmd_e'($urandom_range(0, 1)), col, bits, $urandom_range(0, 3) == 0);
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_BUS_FMT;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    sh_mode    = MODE_24;
    sh_fg      = 24'hFFFFFF;
    sh_bg      = 24'h000000;
    sh_gw      = 4'd8;
    sh_held    = '0;
    sh_held_ok = 1'b0;
    err_count  = 0;
    shown      = 0;
    beats_sent = 0;
    bytes_seen = 0;
    hold_cycles  = 0;
    hold_longest = 0;
    gaps_on    = 1'b1;
    foreach (beats_per_mode[m]) beats_per_mode[m] = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_rgb565();
    test_rgb666_wide_glyph();
    test_rgb444_pairs();
    test_narrow_glyph();
    test_held_drop();
    test_backpressure();
    test_random_traffic();

    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d beats (12/16/18/24-bit: %0d/%0d/%0d/%0d), %0d bus bytes compared",
             beats_sent, beats_per_mode[MODE_12], beats_per_mode[MODE_16],
             beats_per_mode[MODE_18], beats_per_mode[MODE_24], bytes_seen);
    $display("Also: glyph widths 0 to 15, 12-bit hold and flush, %0d-cycle output hold-off",
             hold_longest);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
